// ===== src/smx_pkg.sv =====
// Shared constants, operation codes, state and handshake types for the
// stack machine execute unit. No dependencies.
package smx_pkg;

  localparam int STACK_DEPTH   = 256;
  localparam int DATA_WORDS    = 1024;
  localparam int POSITION_BITS = 16;

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int DAW = $clog2(DATA_WORDS);

  localparam logic [15:0] POS_MASK = 16'((64'(1) << POSITION_BITS) - 64'(1));

  typedef logic [5:0] func_t;

  localparam func_t OP_EXIT   = 6'd0;
  localparam func_t OP_JMP    = 6'd1;
  localparam func_t OP_JF     = 6'd2;
  localparam func_t OP_CALL   = 6'd3;
  localparam func_t OP_ENTER  = 6'd4;
  localparam func_t OP_DROP   = 6'd5;
  localparam func_t OP_PRET   = 6'd6;
  localparam func_t OP_FRET   = 6'd7;
  localparam func_t OP_PRINT  = 6'd8;
  localparam func_t OP_ADDR   = 6'd9;
  localparam func_t OP_STORE  = 6'd10;
  localparam func_t OP_FSTORE = 6'd11;
  localparam func_t OP_LOR    = 6'd12;
  localparam func_t OP_LAND   = 6'd13;
  localparam func_t OP_BOR    = 6'd14;
  localparam func_t OP_XOR    = 6'd15;
  localparam func_t OP_BAND   = 6'd16;
  localparam func_t OP_EQ     = 6'd17;
  localparam func_t OP_NE     = 6'd18;
  localparam func_t OP_LE     = 6'd19;
  localparam func_t OP_LT     = 6'd20;
  localparam func_t OP_GE     = 6'd21;
  localparam func_t OP_GT     = 6'd22;
  localparam func_t OP_SHL    = 6'd23;
  localparam func_t OP_SAR    = 6'd24;
  localparam func_t OP_ADD    = 6'd25;
  localparam func_t OP_SUB    = 6'd26;
  localparam func_t OP_MUL    = 6'd27;
  localparam func_t OP_DIV    = 6'd28;
  localparam func_t OP_MOD    = 6'd29;
  localparam func_t OP_NOT    = 6'd30;
  localparam func_t OP_BNOT   = 6'd31;
  localparam func_t OP_NEG    = 6'd32;
  localparam func_t OP_LOAD   = 6'd33;
  localparam func_t OP_FLOAD  = 6'd34;
  localparam func_t OP_PUSH   = 6'd35;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_DIV  = 2'd1;
  localparam logic [1:0] ERR_OVF  = 2'd2;
  localparam logic [1:0] ERR_UNF  = 2'd3;

  typedef enum logic [1:0] {MD_MUL, MD_DIV, MD_MOD} md_op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH1, ST_FETCH2, ST_FETCH3, ST_EXEC, ST_WAIT, ST_COMMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic fetch1;
    logic fetch2;
    logic fetch3;
    logic exec;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic md_need;
    logic md_done;
    logic out_free;
  } status_t;

endpackage

// ===== src/stack_machine_execute_unit.sv =====
// Stack machine execute unit: one instruction per transfer, one result each.
// Each instruction passes accept, FETCH1-3, EXEC, a WAIT for the multiplier
// or divider when needed, and COMMIT, which can stall on out_stall; the next
// can be accepted in the cycle after the previous commits, so none overlap. The
// rate is set by the single-port stack memory reads and the iterative
// multiplier and divider. Synchronous active-low reset clears the pointers,
// halt and handshake. Depends on smx_pkg, smx_controller, smx_datapath.
module stack_machine_execute_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [5:0]         in_func,
  input  logic signed [63:0] in_immediate,
  input  logic [15:0]        in_current_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_position_set,
  output logic [15:0]        out_new_position,
  output logic               out_advance_after_set,
  output logic               out_print_valid,
  output logic signed [63:0] out_print_value,
  output logic               out_halted,
  output logic [1:0]         out_error_code
);

  smx_pkg::cmd_t    cmd;
  smx_pkg::status_t status;

  smx_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  smx_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .status                (status),
    .in_func               (in_func),
    .in_immediate          (in_immediate),
    .in_current_position   (in_current_position),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_position_set      (out_position_set),
    .out_new_position      (out_new_position),
    .out_advance_after_set (out_advance_after_set),
    .out_print_valid       (out_print_valid),
    .out_print_value       (out_print_value),
    .out_halted            (out_halted),
    .out_error_code        (out_error_code)
  );

endmodule

// ===== src/smx_muldiv.sv =====
// Multi-cycle 64-bit multiplier (three 32x32 partial products) and
// radix-2 signed divider. Depends on smx_pkg.
module smx_muldiv (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  smx_pkg::md_op_t op,
  input  logic [63:0]     opa,
  input  logic [63:0]     opb,
  output logic            done,
  output logic [63:0]     result
);

  logic            busy_r;
  logic            done_r;
  logic [6:0]      cnt_r;
  smx_pkg::md_op_t op_r;
  logic [63:0]     x_r;
  logic [63:0]     y_r;
  logic [63:0]     rem_r;
  logic [63:0]     prod_r;
  logic [63:0]     acc_r;
  logic [63:0]     res_r;
  logic            negq_r;
  logic            negr_r;

  logic [31:0]     ma;
  logic [31:0]     mb;
  logic [63:0]     mul_p;
  logic [64:0]     trial;
  logic [63:0]     sh_prod;

  always_comb begin
    case (cnt_r[1:0])
      2'd0: begin
        ma = x_r[31:0];
        mb = y_r[31:0];
      end
      2'd1: begin
        ma = x_r[31:0];
        mb = y_r[63:32];
      end
      default: begin
        ma = x_r[63:32];
        mb = y_r[31:0];
      end
    endcase
    mul_p   = 64'(ma) * 64'(mb);
    sh_prod = {prod_r[31:0], 32'd0};
    trial   = {rem_r, x_r[63]} - {1'b0, y_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd0;
        op_r   <= op;
        rem_r  <= 64'd0;
        negq_r <= opa[63] ^ opb[63];
        negr_r <= opa[63];
        if (op == smx_pkg::MD_MUL) begin
          x_r <= opa;
          y_r <= opb;
        end else begin
          x_r <= opa[63] ? 64'd0 - opa : opa;
          y_r <= opb[63] ? 64'd0 - opb : opb;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (op_r == smx_pkg::MD_MUL) begin
          prod_r <= mul_p;
          case (cnt_r[1:0])
            2'd1: acc_r <= prod_r;
            2'd2: acc_r <= acc_r + sh_prod;
            2'd3: begin
              res_r  <= acc_r + sh_prod;
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
            default: acc_r <= acc_r;
          endcase
        end else if (cnt_r == 7'd64) begin
          if (op_r == smx_pkg::MD_DIV) begin
            res_r <= negq_r ? 64'd0 - x_r : x_r;
          end else begin
            res_r <= negr_r ? 64'd0 - rem_r : rem_r;
          end
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          x_r   <= {x_r[62:0], ~trial[64]};
          rem_r <= trial[64] ? {rem_r[62:0], x_r[63]} : trial[63:0];
        end
      end
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// ===== src/smx_datapath.sv =====
// Datapath: operand stack and data memories, pointers, instruction
// evaluation, commit and the output register. Depends on smx_pkg, smx_muldiv.
module smx_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  smx_pkg::cmd_t       cmd,
  output smx_pkg::status_t    status,
  input  logic [5:0]          in_func,
  input  logic signed [63:0]  in_immediate,
  input  logic [15:0]         in_current_position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_position_set,
  output logic [15:0]         out_new_position,
  output logic                out_advance_after_set,
  output logic                out_print_valid,
  output logic signed [63:0]  out_print_value,
  output logic                out_halted,
  output logic [1:0]          out_error_code
);

  localparam int SAW = smx_pkg::SAW;
  localparam int SPW = smx_pkg::SPW;
  localparam int DAW = smx_pkg::DAW;

  logic [63:0] stk_mem [smx_pkg::STACK_DEPTH];
  logic [31:0] dmem [smx_pkg::DATA_WORDS];

  smx_pkg::func_t func_r;
  logic [63:0]    imm_r;
  logic [15:0]    cur_r;
  logic [63:0]    top_r;
  logic [63:0]    next_r;
  logic [63:0]    stk_rd_r;
  logic [31:0]    dmem_rd_r;
  logic [SPW-1:0] sp_r;
  logic [SAW-1:0] bp_r;
  logic           halt_r;

  logic           wr_en_r;
  logic [SAW-1:0] wr_addr_r;
  logic [63:0]    wr_data_r;
  logic           md_use_r;
  logic           dw_en_r;
  logic [DAW-1:0] dw_addr_r;
  logic [31:0]    dw_data_r;
  logic [SPW-1:0] sp_new_r;
  logic [SAW-1:0] bp_new_r;
  logic           halt_new_r;
  logic           pset_r;
  logic [15:0]    npos_r;
  logic           adv_r;
  logic           pval_r;
  logic [63:0]    pv_r;
  logic [1:0]     err_r;

  logic           out_valid_r;
  logic           o_pset_r;
  logic [15:0]    o_npos_r;
  logic           o_adv_r;
  logic           o_pval_r;
  logic [63:0]    o_pv_r;
  logic           o_halt_r;
  logic [1:0]     o_err_r;

  logic           is_ret;
  logic           rd_en;
  logic [SAW-1:0] rd_addr;
  logic [SPW-1:0] sp_m1;
  logic [SPW-1:0] sp_m2;
  logic [SPW-1:0] room;
  logic [SPW-1:0] sp_drop;
  logic           has1;
  logic           has2;
  logic           full;
  logic [63:0]    slot_st;
  logic [63:0]    slot_ld;
  logic [SAW-1:0] bp_pop;
  logic [63:0]    alu_r;
  logic           md_start;
  smx_pkg::md_op_t md_op;
  logic           md_done;
  logic [63:0]    md_res;

  logic           e_wr;
  logic [SAW-1:0] e_wa;
  logic [63:0]    e_wd;
  logic           e_md;
  logic           e_dw;
  logic [SPW-1:0] e_sp;
  logic [SAW-1:0] e_bp;
  logic           e_halt;
  logic           e_pset;
  logic [15:0]    e_npos;
  logic           e_adv;
  logic           e_pval;
  logic [63:0]    e_pv;
  logic [1:0]     e_err;

  assign is_ret  = (func_r == smx_pkg::OP_PRET) || (func_r == smx_pkg::OP_FRET);
  assign sp_m1   = sp_r - SPW'(1);
  assign sp_m2   = sp_r - SPW'(2);
  assign room    = SPW'(smx_pkg::STACK_DEPTH - 1) - sp_r;
  assign sp_drop = sp_m1 - imm_r[SPW-1:0];
  assign has1    = sp_r != '0;
  assign has2    = sp_r >= SPW'(2);
  assign full    = sp_r == SPW'(smx_pkg::STACK_DEPTH);
  assign slot_st = 64'(bp_r) + next_r;
  assign slot_ld = 64'(bp_r) + top_r;
  assign bp_pop  = (next_r[31:0] < 32'(smx_pkg::STACK_DEPTH)) ? next_r[SAW-1:0] : '0;

  always_comb begin
    rd_en   = cmd.fetch1 || cmd.fetch2 || cmd.fetch3;
    rd_addr = sp_m1[SAW-1:0];
    if (cmd.fetch2) begin
      rd_addr = is_ret ? bp_r : sp_m2[SAW-1:0];
    end else if (cmd.fetch3) begin
      rd_addr = is_ret ? bp_r - SAW'(1) : slot_ld[SAW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      stk_rd_r <= stk_mem[rd_addr];
    end
    if (cmd.commit && wr_en_r) begin
      stk_mem[wr_addr_r] <= md_use_r ? md_res : wr_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch3) begin
      dmem_rd_r <= dmem[top_r[DAW-1:0]];
    end
    if (cmd.commit && dw_en_r) begin
      dmem[dw_addr_r] <= dw_data_r;
    end
  end

  always_comb begin
    case (func_r)
      smx_pkg::OP_LOR:  alu_r = 64'((next_r != '0) || (top_r != '0));
      smx_pkg::OP_LAND: alu_r = 64'((next_r != '0) && (top_r != '0));
      smx_pkg::OP_BOR:  alu_r = next_r | top_r;
      smx_pkg::OP_XOR:  alu_r = next_r ^ top_r;
      smx_pkg::OP_BAND: alu_r = next_r & top_r;
      smx_pkg::OP_EQ:   alu_r = 64'(next_r == top_r);
      smx_pkg::OP_NE:   alu_r = 64'(next_r != top_r);
      smx_pkg::OP_LE:   alu_r = 64'($signed(next_r) <= $signed(top_r));
      smx_pkg::OP_LT:   alu_r = 64'($signed(next_r) < $signed(top_r));
      smx_pkg::OP_GE:   alu_r = 64'($signed(next_r) >= $signed(top_r));
      smx_pkg::OP_GT:   alu_r = 64'($signed(next_r) > $signed(top_r));
      smx_pkg::OP_SHL:  alu_r = (top_r[63:6] == '0) ? next_r << top_r[5:0] : 64'd0;
      smx_pkg::OP_SAR: begin
        if (top_r[63:6] != '0) begin
          alu_r = {64{next_r[63]}};
        end else begin
          alu_r = 64'($signed(next_r) >>> top_r[5:0]);
        end
      end
      smx_pkg::OP_ADDR: alu_r = next_r + top_r;
      smx_pkg::OP_ADD:  alu_r = next_r + top_r;
      smx_pkg::OP_SUB:  alu_r = next_r - top_r;
      smx_pkg::OP_NOT:  alu_r = 64'(top_r == '0);
      smx_pkg::OP_BNOT: alu_r = ~top_r;
      smx_pkg::OP_NEG:  alu_r = 64'd0 - top_r;
      smx_pkg::OP_LOAD: begin
        if (top_r < 64'(smx_pkg::DATA_WORDS)) begin
          alu_r = {{32{dmem_rd_r[31]}}, dmem_rd_r};
        end else begin
          alu_r = 64'd0;
        end
      end
      smx_pkg::OP_FLOAD: alu_r = (slot_ld < 64'(smx_pkg::STACK_DEPTH)) ? stk_rd_r : 64'd0;
      default: alu_r = 64'd0;
    endcase
  end

  always_comb begin
    e_wr   = 1'b0;
    e_wa   = sp_m1[SAW-1:0];
    e_wd   = alu_r;
    e_md   = 1'b0;
    e_dw   = 1'b0;
    e_sp   = sp_r;
    e_bp   = bp_r;
    e_halt = halt_r;
    e_pset = 1'b0;
    e_npos = top_r[15:0] & smx_pkg::POS_MASK;
    e_adv  = 1'b0;
    e_pval = 1'b0;
    e_pv   = 64'd0;
    e_err  = smx_pkg::ERR_NONE;
    if (!halt_r) begin
      case (func_r)
        smx_pkg::OP_EXIT: e_halt = 1'b1;
        smx_pkg::OP_JMP: begin
          if (!has1) begin
            e_err = smx_pkg::ERR_UNF;
          end else begin
            e_pset = 1'b1;
            e_adv  = 1'b1;
            e_sp   = sp_m1;
          end
        end
        smx_pkg::OP_JF: begin
          if (!has2) begin
            e_err = smx_pkg::ERR_UNF;
          end else begin
            e_sp   = sp_m2;
            e_pset = next_r == '0;
            e_adv  = next_r == '0;
          end
        end
        smx_pkg::OP_CALL: begin
          if (!has1) begin
            e_err = smx_pkg::ERR_UNF;
          end else begin
            e_pset = 1'b1;
            e_wr   = 1'b1;
            e_wd   = 64'(cur_r);
          end
        end
        smx_pkg::OP_ENTER: begin
          if (full || imm_r[63] || (imm_r > 64'(room))) begin
            e_err = smx_pkg::ERR_OVF;
          end else begin
            e_wr = 1'b1;
            e_wa = sp_r[SAW-1:0];
            e_wd = 64'(bp_r);
            e_bp = sp_r[SAW-1:0];
            e_sp = sp_r + SPW'(1) + imm_r[SPW-1:0];
          end
        end
        smx_pkg::OP_DROP: begin
          if (!has1 || imm_r[63] || (imm_r > 64'(sp_m1))) begin
            e_err = smx_pkg::ERR_UNF;
          end else begin
            e_wr = 1'b1;
            e_wa = sp_drop[SAW-1:0];
            e_wd = top_r;
            e_sp = sp_drop + SPW'(1);
          end
        end
        smx_pkg::OP_PRET: begin
          if (bp_r == '0) begin
            e_err = smx_pkg::ERR_UNF;
          end else begin
            e_bp   = bp_pop;
            e_sp   = SPW'(bp_r) - SPW'(1);
            e_pset = 1'b1;
            e_npos = stk_rd_r[15:0] & smx_pkg::POS_MASK;
          end
        end
        smx_pkg::OP_FRET: begin
          if (!has1 || (bp_r == '0)) begin
            e_err = smx_pkg::ERR_UNF;
          end else begin
            e_bp   = bp_pop;
            e_sp   = SPW'(bp_r);
            e_pset = 1'b1;
            e_npos = stk_rd_r[15:0] & smx_pkg::POS_MASK;
            e_wr   = 1'b1;
            e_wa   = bp_r - SAW'(1);
            e_wd   = top_r;
          end
        end
        smx_pkg::OP_PRINT: begin
          if (!has1) begin
            e_err = smx_pkg::ERR_UNF;
          end else begin
            e_pval = 1'b1;
            e_pv   = top_r;
            e_sp   = sp_m1;
          end
        end
        smx_pkg::OP_STORE: begin
          if (!has2) begin
            e_err = smx_pkg::ERR_UNF;
          end else begin
            e_dw = next_r < 64'(smx_pkg::DATA_WORDS);
            e_sp = sp_m2;
          end
        end
        smx_pkg::OP_FSTORE: begin
          if (!has2) begin
            e_err = smx_pkg::ERR_UNF;
          end else begin
            e_wr = slot_st < 64'(smx_pkg::STACK_DEPTH);
            e_wa = slot_st[SAW-1:0];
            e_wd = top_r;
            e_sp = sp_m2;
          end
        end
        smx_pkg::OP_NOT, smx_pkg::OP_BNOT, smx_pkg::OP_NEG,
        smx_pkg::OP_LOAD, smx_pkg::OP_FLOAD: begin
          if (!has1) begin
            e_err = smx_pkg::ERR_UNF;
          end else begin
            e_wr = 1'b1;
          end
        end
        smx_pkg::OP_PUSH: begin
          if (full) begin
            e_err = smx_pkg::ERR_OVF;
          end else begin
            e_wr = 1'b1;
            e_wa = sp_r[SAW-1:0];
            e_wd = imm_r;
            e_sp = sp_r + SPW'(1);
          end
        end
        default: begin
          if ((func_r >= smx_pkg::OP_ADDR) && (func_r <= smx_pkg::OP_MOD)) begin
            if (!has2) begin
              e_err = smx_pkg::ERR_UNF;
            end else if (((func_r == smx_pkg::OP_DIV) || (func_r == smx_pkg::OP_MOD))
                         && (top_r == '0)) begin
              e_err = smx_pkg::ERR_DIV;
            end else begin
              e_wr = 1'b1;
              e_wa = sp_m2[SAW-1:0];
              e_sp = sp_m1;
              e_md = func_r >= smx_pkg::OP_MUL;
            end
          end
        end
      endcase
      if (e_err != smx_pkg::ERR_NONE) begin
        e_halt = 1'b1;
        e_wr   = 1'b0;
        e_dw   = 1'b0;
        e_md   = 1'b0;
        e_sp   = sp_r;
        e_bp   = bp_r;
        e_pset = 1'b0;
        e_adv  = 1'b0;
        e_pval = 1'b0;
        e_pv   = 64'd0;
      end
    end
  end

  always_comb begin
    case (func_r)
      smx_pkg::OP_MUL: md_op = smx_pkg::MD_MUL;
      smx_pkg::OP_DIV: md_op = smx_pkg::MD_DIV;
      default:         md_op = smx_pkg::MD_MOD;
    endcase
  end

  assign md_start = cmd.exec && e_md;

  smx_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (md_start),
    .op     (md_op),
    .opa    (next_r),
    .opb    (top_r),
    .done   (md_done),
    .result (md_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= in_func;
      imm_r  <= in_immediate;
      cur_r  <= in_current_position;
    end
    if (cmd.fetch2) begin
      top_r <= stk_rd_r;
    end
    if (cmd.fetch3) begin
      next_r <= stk_rd_r;
    end
    if (cmd.exec) begin
      wr_en_r    <= e_wr;
      wr_addr_r  <= e_wa;
      wr_data_r  <= e_wd;
      md_use_r   <= e_md;
      dw_en_r    <= e_dw;
      dw_addr_r  <= next_r[DAW-1:0];
      dw_data_r  <= top_r[31:0];
      sp_new_r   <= e_sp;
      bp_new_r   <= e_bp;
      halt_new_r <= e_halt;
      pset_r     <= e_pset;
      npos_r     <= e_pset ? e_npos : 16'd0;
      adv_r      <= e_adv;
      pval_r     <= e_pval;
      pv_r       <= e_pv;
      err_r      <= e_err;
    end
    if (cmd.commit) begin
      o_pset_r <= pset_r;
      o_npos_r <= npos_r;
      o_adv_r  <= adv_r;
      o_pval_r <= pval_r;
      o_pv_r   <= pv_r;
      o_halt_r <= halt_new_r;
      o_err_r  <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      bp_r        <= '0;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.commit) begin
        sp_r        <= sp_new_r;
        bp_r        <= bp_new_r;
        halt_r      <= halt_new_r;
        out_valid_r <= 1'b1;
      end
    end
  end

  assign status.md_need  = e_md;
  assign status.md_done  = md_done;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid             = out_valid_r;
  assign out_position_set      = o_pset_r;
  assign out_new_position      = o_npos_r;
  assign out_advance_after_set = o_adv_r;
  assign out_print_valid       = o_pval_r;
  assign out_print_value       = o_pv_r;
  assign out_halted            = o_halt_r;
  assign out_error_code        = o_err_r;

endmodule

// ===== src/smx_controller.sv =====
// Controller state machine: sequences fetch, evaluation, arithmetic wait
// and commit for each instruction. Depends on smx_pkg.
module smx_controller (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  smx_pkg::status_t status,
  output smx_pkg::cmd_t    cmd
);

  smx_pkg::state_t state_r;
  smx_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smx_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      smx_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = smx_pkg::ST_FETCH1;
        end
      end
      smx_pkg::ST_FETCH1: begin
        cmd.fetch1 = 1'b1;
        state_nxt  = smx_pkg::ST_FETCH2;
      end
      smx_pkg::ST_FETCH2: begin
        cmd.fetch2 = 1'b1;
        state_nxt  = smx_pkg::ST_FETCH3;
      end
      smx_pkg::ST_FETCH3: begin
        cmd.fetch3 = 1'b1;
        state_nxt  = smx_pkg::ST_EXEC;
      end
      smx_pkg::ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = status.md_need ? smx_pkg::ST_WAIT : smx_pkg::ST_COMMIT;
      end
      smx_pkg::ST_WAIT: begin
        if (status.md_done) begin
          state_nxt = smx_pkg::ST_COMMIT;
        end
      end
      smx_pkg::ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = smx_pkg::ST_IDLE;
        end
      end
      default: state_nxt = smx_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== tb/sv/stack_machine_execute_unit_checker.sv =====
`timescale 1ns / 100ps
// Checker for the stack machine execute unit: watches both channels, models the
// stack, frames and data memory, and compares every result. Depends on smx_pkg.
module stack_machine_execute_unit_checker
  import smx_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [5:0]         in_func,
  input  logic signed [63:0] in_immediate,
  input  logic [15:0]        in_current_position,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_position_set,
  input  logic [15:0]        out_new_position,
  input  logic               out_advance_after_set,
  input  logic               out_print_valid,
  input  logic signed [63:0] out_print_value,
  input  logic               out_halted,
  input  logic [1:0]         out_error_code,
  output int                 fail_count,
  output int                 outstanding
);

  typedef struct {
    logic        position_set;
    logic [15:0] new_position;
    logic        advance_after_set;
    logic        print_valid;
    logic [63:0] print_value;
    logic        halted;
    logic [1:0]  error_code;
  } step_result_t;

  step_result_t pending_results[$];

  logic [63:0] stack_mem [STACK_DEPTH];
  logic [31:0] data_mem [DATA_WORDS];
  int unsigned sp;
  int unsigned bp;
  bit          halt_seen;
  logic [1:0]  fault;

  function automatic void raise(logic [1:0] code);
    if (fault == ERR_NONE) fault = code;
  endfunction

  function automatic void push_slot(logic [63:0] v);
    if (sp >= STACK_DEPTH) begin
      raise(ERR_OVF);
      return;
    end
    stack_mem[sp] = v;
    sp++;
  endfunction

  function automatic logic [63:0] pop_slot();
    if (sp == 0) begin
      raise(ERR_UNF);
      return '0;
    end
    sp--;
    return stack_mem[sp];
  endfunction

  function automatic void leave_frame();
    logic [63:0] v;
    sp = bp + 1;
    if (sp > STACK_DEPTH) sp = STACK_DEPTH;
    v = pop_slot();
    bp = v[31:0];
    if (bp >= STACK_DEPTH) bp = 0;
  endfunction

  function automatic logic [63:0] divide(logic [63:0] a, logic [63:0] b, bit want_mod);
    if (b == '0) begin
      raise(ERR_DIV);
      return '0;
    end
    if (b == '1) return want_mod ? 64'd0 : -a;
    return want_mod ? 64'($signed(a) % $signed(b)) : 64'($signed(a) / $signed(b));
  endfunction

  function automatic step_result_t exec_instr(logic [5:0] op, logic [63:0] imm,
                                              logic [15:0] cur);
    step_result_t res;
    logic [63:0] a, b, r, npos;
    logic        pset, adv;
    res = '{default: '0};
    npos = '0;
    pset = 0;
    adv = 0;
    if (halt_seen) begin
      res.halted = 1;
      return res;
    end
    fault = ERR_NONE;
    case (op)
      OP_EXIT: halt_seen = 1;
      OP_JMP: begin
        npos = pop_slot();
        pset = 1;
        adv = 1;
      end
      OP_JF: begin
        a = pop_slot();
        b = pop_slot();
        if (b == '0) begin
          npos = a;
          pset = 1;
          adv = 1;
        end
      end
      OP_CALL: begin
        npos = pop_slot();
        pset = 1;
        push_slot(64'(cur));
      end
      OP_ENTER: begin
        push_slot(64'(bp));
        if (fault == ERR_NONE) begin
          bp = sp - 1;
          if (imm[63] || imm > 64'(STACK_DEPTH - sp)) raise(ERR_OVF);
          else sp += imm[31:0];
        end
      end
      OP_DROP: begin
        a = pop_slot();
        if (imm[63] || imm > 64'(sp)) raise(ERR_UNF);
        else sp -= imm[31:0];
        push_slot(a);
      end
      OP_PRET: begin
        leave_frame();
        npos = pop_slot();
        pset = 1;
      end
      OP_FRET: begin
        a = pop_slot();
        leave_frame();
        npos = pop_slot();
        pset = 1;
        push_slot(a);
      end
      OP_PRINT: begin
        res.print_value = pop_slot();
        res.print_valid = 1;
      end
      OP_STORE: begin
        b = pop_slot();
        a = pop_slot();
        if (fault == ERR_NONE && a < DATA_WORDS) data_mem[a[9:0]] = b[31:0];
      end
      OP_FSTORE: begin
        b = pop_slot();
        a = pop_slot();
        r = 64'(bp) + a;
        if (fault == ERR_NONE && r < STACK_DEPTH) stack_mem[r[7:0]] = b;
      end
      OP_LOAD: begin
        a = pop_slot();
        r = '0;
        if (a < DATA_WORDS) r = {{32{data_mem[a[9:0]][31]}}, data_mem[a[9:0]]};
        push_slot(r);
      end
      OP_FLOAD: begin
        a = pop_slot();
        r = 64'(bp) + a;
        push_slot(r < STACK_DEPTH ? stack_mem[r[7:0]] : 64'd0);
      end
      OP_PUSH: push_slot(imm);
      OP_NOT, OP_BNOT, OP_NEG: begin
        a = pop_slot();
        if (op == OP_NOT) r = 64'(a == '0);
        else if (op == OP_BNOT) r = ~a;
        else r = -a;
        push_slot(r);
      end
      default: begin
        if (op == OP_ADDR || (op >= OP_LOR && op <= OP_MOD)) begin
          b = pop_slot();
          a = pop_slot();
          case (op)
            OP_ADDR, OP_ADD: r = a + b;
            OP_LOR:  r = 64'(a != '0 || b != '0);
            OP_LAND: r = 64'(a != '0 && b != '0);
            OP_BOR:  r = a | b;
            OP_XOR:  r = a ^ b;
            OP_BAND: r = a & b;
            OP_EQ:   r = 64'(a == b);
            OP_NE:   r = 64'(a != b);
            OP_LE:   r = 64'($signed(a) <= $signed(b));
            OP_LT:   r = 64'($signed(a) < $signed(b));
            OP_GE:   r = 64'($signed(a) >= $signed(b));
            OP_GT:   r = 64'($signed(a) > $signed(b));
            OP_SHL:  r = b < 64 ? a << b[5:0] : 64'd0;
            OP_SAR:  r = b < 64 ? 64'($signed(a) >>> b[5:0]) : {64{a[63]}};
            OP_SUB:  r = a - b;
            OP_MUL:  r = a * b;
            OP_DIV:  r = divide(a, b, 0);
            default: r = divide(a, b, 1);
          endcase
          if (fault == ERR_NONE) push_slot(r);
        end
      end
    endcase
    if (fault != ERR_NONE) begin
      halt_seen = 1;
      res = '{default: '0};
      res.halted = 1;
      res.error_code = fault;
      return res;
    end
    res.position_set = pset;
    res.new_position = pset ? npos[15:0] & POS_MASK : 16'd0;
    res.advance_after_set = adv;
    res.halted = halt_seen;
    return res;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    step_result_t exp_r;
    if (!rst_n) begin
      sp = 0;
      bp = 0;
      halt_seen = 0;
      fail_count = 0;
      pending_results.delete();
    end else begin
      if (in_valid && !in_stall)
        pending_results.push_back(exec_instr(in_func, in_immediate, in_current_position));
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no instruction outstanding");
          fail_count++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("position_set", exp_r.position_set, out_position_set);
          check_field("new_position", exp_r.new_position, out_new_position);
          check_field("advance_after_set", exp_r.advance_after_set, out_advance_after_set);
          check_field("print_valid", exp_r.print_valid, out_print_valid);
          check_field("print_value", exp_r.print_value, out_print_value);
          check_field("halted", exp_r.halted, out_halted);
          check_field("error_code", exp_r.error_code, out_error_code);
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

// ===== tb/sv/stack_machine_execute_unit_tb.sv =====
`timescale 1ns / 100ps
// Top of the stack machine execute unit testbench: clock, reset, instruction
// streams and verdict. Depends on smx_pkg, the unit and its checker.
module stack_machine_execute_unit_tb;
  import smx_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam logic [63:0] MAX_V = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MIN_V = 64'h8000_0000_0000_0000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [5:0]         in_func = '0;
  logic signed [63:0] in_immediate = '0;
  logic [15:0]        in_current_position = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic               out_position_set;
  logic [15:0]        out_new_position;
  logic               out_advance_after_set;
  logic               out_print_valid;
  logic signed [63:0] out_print_value;
  logic               out_halted;
  logic [1:0]         out_error_code;
  int                 fail_count;
  int                 outstanding;

  int  issued = 0;
  int  depth = 0;
  bit  steady = 0;
  bit  word_written [DATA_WORDS];
  int  idle_cycles = 0;

  always #5 clk = ~clk;

  stack_machine_execute_unit i_dut (.*);

  stack_machine_execute_unit_checker i_checker (.*);

  always @(posedge clk) begin
    out_stall <= steady ? 1'b0 : ($urandom_range(99) < 37);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] operand();
    case ($urandom_range(7))
      0: return MAX_V;
      1: return MIN_V;
      2: return 64'($urandom_range(70));
      3: return -64'($urandom_range(3));
      default: return rand64();
    endcase
  endfunction

  task automatic send(logic [5:0] op, logic [63:0] imm);
    if (!steady && $urandom_range(99) < 37) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < 37) @(posedge clk);
    end
    in_valid <= 1;
    in_func <= op;
    in_immediate <= imm;
    in_current_position <= 16'($urandom);
    issued++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic literal(logic [63:0] v);
    send(OP_PUSH, v);
    depth++;
  endtask

  task automatic pop_print();
    send(OP_PRINT, rand64());
    depth--;
  endtask

  task automatic binary(logic [5:0] op, logic [63:0] a, logic [63:0] b);
    literal(a);
    literal(b);
    send(op, rand64());
    depth--;
  endtask

  task automatic frame_sequence();
    int          nargs, nlocals, base;
    logic [63:0] idx;
    nargs = $urandom_range(3);
    nlocals = $urandom_range(4);
    repeat (nargs) literal(operand());
    literal(rand64());
    send(OP_CALL, rand64());
    base = depth;
    send(OP_ENTER, 64'(nlocals));
    depth += 1 + nlocals;
    for (int i = 1; i <= nlocals; i++) begin
      binary(OP_FSTORE, 64'(i), operand());
      depth--;
    end
    if ($urandom_range(3) == 0) begin
      binary(OP_FSTORE, 64'(300 + $urandom_range(999)), operand());
      depth--;
    end
    repeat ($urandom_range(3)) begin
      case ($urandom_range(5))
        0: idx = 64'd256 + 64'($urandom_range(5000));
        1: idx = -(64'd1 << $urandom_range(40, 62));
        default: idx = 64'($urandom_range(nlocals + nargs + 1)) - 64'(nargs + 1);
      endcase
      literal(idx);
      send(OP_FLOAD, rand64());
    end
    if ($urandom_range(1)) begin
      literal(operand());
      send(OP_FRET, rand64());
      depth = base;
      if (nargs > 0 && $urandom_range(1)) begin
        idx = 64'($urandom_range(nargs));
        send(OP_DROP, idx);
        depth -= int'(idx);
      end
    end else begin
      send(OP_PRET, rand64());
      depth = base - 1;
    end
  endtask

  task automatic random_item();
    int          pick;
    logic [5:0]  op;
    logic [63:0] a, b;
    pick = $urandom_range(99);
    if (depth > 200 || (pick < 10 && depth > 0)) begin
      pop_print();
    end else if (pick < 40) begin
      op = $urandom_range(4) == 0 ? OP_ADDR : 6'($urandom_range(OP_LOR, OP_MOD));
      a = operand();
      b = operand();
      if ((op == OP_DIV || op == OP_MOD) && b == '0) b = 64'd7;
      binary(op, a, b);
    end else if (pick < 48) begin
      literal(operand());
      send(6'($urandom_range(OP_NOT, OP_NEG)), rand64());
    end else if (pick < 56) begin
      a = $urandom_range(4) ? 64'($urandom_range(DATA_WORDS - 1)) : rand64() | 64'h1_0000;
      if (a < DATA_WORDS) word_written[a] = 1;
      binary(OP_STORE, a, operand());
      depth--;
    end else if (pick < 63) begin
      a = 64'($urandom_range(DATA_WORDS - 1));
      if (!word_written[a]) a = rand64() | 64'h1_0000;
      literal(a);
      send(OP_LOAD, rand64());
    end else if (pick < 67) begin
      literal(rand64());
      send(OP_JMP, rand64());
      depth--;
    end else if (pick < 71) begin
      literal($urandom_range(1) ? 64'd0 : operand());
      literal(rand64());
      send(OP_JF, rand64());
      depth -= 2;
    end else if (pick < 74) begin
      literal(rand64());
      send(OP_CALL, rand64());
    end else if (pick < 88) begin
      frame_sequence();
    end else if (pick < 93) begin
      send(6'($urandom_range(36, 63)), rand64());
    end else begin
      literal(operand());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    literal(MAX_V);
    pop_print();
    binary(OP_DIV, MIN_V, -64'd1);
    binary(OP_MOD, MIN_V, -64'd1);
    binary(OP_SAR, MIN_V, 64'd64);
    binary(OP_SHL, 64'd1, 64'd63);
    binary(OP_MUL, MAX_V, MAX_V);
    binary(OP_ADD, MAX_V, 64'd1);
    send(OP_NOT, '0);
    send(OP_BNOT, '0);
    send(OP_NEG, '0);

    while (issued < 1800) begin
      steady = issued > 700 && issued < 1000;
      if (issued > 1200 && issued < 1210) begin
        while (depth < STACK_DEPTH) literal(rand64());
        while (depth > 0) pop_print();
      end
      random_item();
    end
    steady = 0;

    case ($urandom_range(6))
      0: send(OP_EXIT, rand64());
      1: binary(OP_DIV, operand(), '0);
      2: binary(OP_MOD, operand(), '0);
      3: while (depth >= 0) pop_print();
      4: while (depth <= STACK_DEPTH) literal(rand64());
      5: send(OP_ENTER, -64'($urandom_range(1, 9)));
      default: begin
        literal(operand());
        send(OP_DROP, 64'(depth + $urandom_range(1, 5)));
      end
    endcase
    repeat (6) send(6'($urandom), rand64());
    in_valid <= 0;

    while (outstanding != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
